>>> rtl/brg_pkg.sv
// Package: shared types and constants for the bicycle rollout generator.
`timescale 1ns / 1ps
package brg_pkg;

  localparam int TAB_LEN = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [21:0] RAD_TO_BAU = 22'd2670177;
  localparam logic signed [21:0] POS_MAX = 22'sd2097151;
  localparam logic signed [21:0] POS_MIN = -22'sd2097152;

  typedef enum logic [2:0] {
    CFG_SPAN    = 3'd0,
    CFG_COUNT   = 3'd1,
    CFG_PREP    = 3'd2,
    CFG_STEER   = 3'd3,
    CFG_HOLD    = 3'd4,
    CFG_RATIO   = 3'd5,
    CFG_STEPLEN = 3'd6,
    CFG_YAW     = 3'd7
  } cfg_idx_t;

  // Shared CORDIC unit modes
  typedef enum logic [1:0] {
    CM_ROT  = 2'd0,
    CM_VEC  = 2'd1
  } cordic_mode_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV,
    S_STEP,
    S_ROT_A,
    S_ROT_A_W,
    S_TANMUL,
    S_VEC,
    S_VEC_W,
    S_ROT_H,
    S_ROT_H_W,
    S_ROT_B,
    S_ROT_B_W,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_P,
    S_MUL_DH,
    S_UPD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic         start;
    cordic_mode_t mode;
  } cordic_ctl_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:  atan_entry = 34'sd536870912;
      5'd1:  atan_entry = 34'sd316933406;
      5'd2:  atan_entry = 34'sd167458907;
      5'd3:  atan_entry = 34'sd85004756;
      5'd4:  atan_entry = 34'sd42667331;
      5'd5:  atan_entry = 34'sd21354465;
      5'd6:  atan_entry = 34'sd10679838;
      5'd7:  atan_entry = 34'sd5340245;
      5'd8:  atan_entry = 34'sd2670163;
      5'd9:  atan_entry = 34'sd1335087;
      5'd10: atan_entry = 34'sd667544;
      5'd11: atan_entry = 34'sd333772;
      5'd12: atan_entry = 34'sd166886;
      5'd13: atan_entry = 34'sd83443;
      5'd14: atan_entry = 34'sd41722;
      5'd15: atan_entry = 34'sd20861;
      5'd16: atan_entry = 34'sd10430;
      5'd17: atan_entry = 34'sd5215;
      5'd18: atan_entry = 34'sd2608;
      5'd19: atan_entry = 34'sd1304;
      5'd20: atan_entry = 34'sd652;
      5'd21: atan_entry = 34'sd326;
      5'd22: atan_entry = 34'sd163;
      5'd23: atan_entry = 34'sd81;
      default: atan_entry = '0;
    endcase
  endfunction

endpackage

>>> rtl/bicycle_rollout_generator_core.sv
// Top level: sequencer, configuration registers and output register of the rollout generator.
`timescale 1ns / 1ps
// Each accepted sample_index starts a rollout from the zero pose and produces
// prepare_steps+steer_steps+hold_steps points (clamped to MAX_HORIZON), the last
// one flagged by last_point. A rollout first forms the steering angle with a
// bit-serial divider; each point then takes four passes of the shared CORDIC
// unit plus the sequencing, multiply and update states, and waits in S_OUT
// while the output is stalled. The CORDIC unit is the bottleneck. No new sample
// is accepted until the last point has been loaded into the output register.
module bicycle_rollout_generator_core #(
  parameter int MAX_HORIZON       = 64,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         sample_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [21:0] point_x,
  output logic signed [21:0] point_y,
  output logic signed [15:0] point_heading,
  output logic               last_point
);
  import brg_pkg::*;

  logic [14:0] steer_span;
  logic [5:0]  sample_count;
  logic [6:0]  prepare_steps, steer_steps, hold_steps;
  logic [15:0] rear_ratio, step_length, yaw_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_span    <= 15'd5461;
      sample_count  <= 6'd20;
      prepare_steps <= 7'd3;
      steer_steps   <= 7'd20;
      hold_steps    <= 7'd20;
      rear_ratio    <= 16'd32768;
      step_length   <= 16'd128;
      yaw_gain      <= 16'd95;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SPAN:    steer_span    <= cfg_data[14:0];
        CFG_COUNT:   sample_count  <= cfg_data[5:0];
        CFG_PREP:    prepare_steps <= cfg_data[6:0];
        CFG_STEER:   steer_steps   <= cfg_data[6:0];
        CFG_HOLD:    hold_steps    <= cfg_data[6:0];
        CFG_RATIO:   rear_ratio    <= cfg_data;
        CFG_STEPLEN: step_length   <= cfg_data;
        CFG_YAW:     yaw_gain      <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  // Working registers
  logic [6:0]         total, step;
  logic [15:0]        steer_ang;
  logic [21:0]        num_mag;     // |span*diff| then quotient
  logic               num_neg;
  logic [5:0]         rem;
  logic [4:0]         dcnt;
  logic signed [33:0] sc, ss, tan_y;
  logic [31:0]        beta;
  logic signed [33:0] hc, hs, bs;
  logic signed [21:0] pose_x, pose_y;
  logic [15:0]        pose_heading;
  logic signed [40:0] dx, dy;
  logic signed [33:0] p;
  logic signed [15:0] dh;

  cordic_ctl_t        cctl;
  logic [31:0]        c_angle;
  logic               c_done;
  logic signed [33:0] c_x, c_y;
  logic [31:0]        c_z;

  brg_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk(clk), .rst(rst), .ctl(cctl), .angle(c_angle),
    .vec_x(sc), .vec_y(tan_y),
    .done(c_done), .res_x(c_x), .res_y(c_y), .res_z(c_z)
  );

  logic [8:0]  total_raw;
  logic [6:0]  step_sum;
  logic        in_steer;
  logic signed [7:0] diff;
  logic signed [22:0] prod;
  logic [6:0]  trial;

  assign total_raw = 9'(prepare_steps) + 9'(steer_steps) + 9'(hold_steps);
  assign in_steer  = ({1'b0, step} >= {1'b0, prepare_steps}) &&
                     ({1'b0, step} < ({1'b0, prepare_steps} + {1'b0, steer_steps}));
  assign step_sum  = step;
  assign diff      = $signed({2'b00, sample_index}) - $signed({3'b000, sample_count[5:1]});
  assign prod      = $signed({1'b0, steer_span}) * diff;
  assign trial     = {rem, num_mag[21]};

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_DIV;
      S_DIV:     if (dcnt == 5'd21) state_next = S_STEP;
      S_STEP:    state_next = (step == total) ? S_IDLE : S_ROT_A;
      S_ROT_A:   state_next = S_ROT_A_W;
      S_ROT_A_W: if (c_done) state_next = S_TANMUL;
      S_TANMUL:  state_next = S_VEC;
      S_VEC:     state_next = S_VEC_W;
      S_VEC_W:   if (c_done) state_next = S_ROT_H;
      S_ROT_H:   state_next = S_ROT_H_W;
      S_ROT_H_W: if (c_done) state_next = S_ROT_B;
      S_ROT_B:   state_next = S_ROT_B_W;
      S_ROT_B_W: if (c_done) state_next = S_MUL_X;
      S_MUL_X:   state_next = S_MUL_Y;
      S_MUL_Y:   state_next = S_MUL_P;
      S_MUL_P:   state_next = S_MUL_DH;
      S_MUL_DH:  state_next = S_UPD;
      S_UPD:     state_next = S_OUT;
      S_OUT:     if (!out_valid || !out_stall) state_next = S_STEP;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cctl.start = 1'b0;
    cctl.mode  = CM_ROT;
    c_angle    = '0;
    case (state)
      S_ROT_A: begin
        cctl.start = 1'b1;
        c_angle = in_steer ? {steer_ang, 16'h0} : 32'h0;
      end
      S_VEC: begin
        cctl.start = 1'b1;
        cctl.mode  = CM_VEC;
      end
      S_ROT_H: begin
        cctl.start = 1'b1;
        c_angle = {pose_heading, 16'h0} + beta;
      end
      S_ROT_B: begin
        cctl.start = 1'b1;
        c_angle = beta;
      end
      default: ;
    endcase
  end

  logic signed [50:0] mx;
  logic signed [50:0] mp;
  logic signed [55:0] mdh;
  logic signed [22:0] nx, ny;
  logic signed [49:0] mr;

  assign mx  = $signed({1'b0, step_length}) * (state == S_MUL_X ? hc : hs);
  assign mp  = $signed({1'b0, yaw_gain}) * bs;
  assign mr  = $signed({1'b0, rear_ratio}) * ss;
  assign mdh = p * $signed({1'b0, RAD_TO_BAU});
  assign nx  = 23'(pose_x) + 23'(dx);
  assign ny  = 23'(pose_y) + 23'(dy);

  function automatic logic signed [21:0] sat(input logic signed [22:0] v);
    if (v > 23'(POS_MAX))      sat = POS_MAX;
    else if (v < 23'(POS_MIN)) sat = POS_MIN;
    else                       sat = v[21:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          total   <= (total_raw > 9'(MAX_HORIZON)) ? 7'(MAX_HORIZON) : total_raw[6:0];
          step    <= '0;
          pose_x  <= '0;
          pose_y  <= '0;
          pose_heading <= '0;
          num_neg <= prod[22];
          num_mag <= prod[22] ? 22'(-prod) : prod[21:0];
          rem     <= '0;
          dcnt    <= '0;
        end
        S_DIV: begin
          // Restoring division, one quotient bit a cycle
          dcnt <= dcnt + 5'd1;
          if (sample_count != 6'd0 && trial >= {1'b0, sample_count}) begin
            rem     <= 6'(trial - {1'b0, sample_count});
            num_mag <= {num_mag[20:0], 1'b1};
          end else begin
            rem     <= trial[5:0];
            num_mag <= {num_mag[20:0], 1'b0};
          end
          if (dcnt == 5'd21) begin
            if (sample_count == 6'd0)    steer_ang <= '0;
            else if (num_neg) steer_ang <= 16'(-{num_mag[20:0], 1'b0}
                                          - ((trial >= {1'b0, sample_count}) ? 22'd1 : 22'd0));
            else steer_ang <= 16'({num_mag[20:0], (trial >= {1'b0, sample_count})});
          end
        end
        S_ROT_A_W: if (c_done) begin
          sc <= c_x;
          ss <= c_y;
        end
        S_TANMUL: tan_y <= 34'(mr >>> 16);
        S_VEC_W:  if (c_done) beta <= (sc == 0 && tan_y == 0) ? 32'h0 : c_z;
        S_ROT_H_W: if (c_done) begin
          hc <= c_x;
          hs <= c_y;
        end
        S_ROT_B_W: if (c_done) bs <= c_y;
        S_MUL_X: dx <= 41'((mx + 51'sd536870912) >>> 30);
        S_MUL_Y: dy <= 41'((mx + 51'sd536870912) >>> 30);
        S_MUL_P: p  <= 34'(mp >>> 16);
        S_MUL_DH: dh <= 16'((mdh + 56'sd536870912) >>> 30);
        S_UPD: begin
          pose_x <= sat(nx);
          pose_y <= sat(ny);
          pose_heading <= pose_heading + dh;
          step <= step + 7'd1;
        end
        S_OUT: if (!out_valid || !out_stall) begin
          out_valid     <= 1'b1;
          point_x       <= pose_x;
          point_y       <= pose_y;
          point_heading <= pose_heading;
          last_point    <= (step_sum == total);
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/brg_cordic.sv
// Iterative CORDIC unit: rotation (cos/sin) and vectoring (atan), one micro-rotation a cycle.
`timescale 1ns / 1ps
module brg_cordic #(
  parameter int ITERATIONS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  brg_pkg::cordic_ctl_t        ctl,
  input  logic [31:0]                 angle,
  input  logic signed [33:0]          vec_x,
  input  logic signed [33:0]          vec_y,
  output logic                        done,
  output logic signed [33:0]          res_x,
  output logic signed [33:0]          res_y,
  output logic [31:0]                 res_z
);
  import brg_pkg::*;

  localparam int N = (ITERATIONS < TAB_LEN) ? ITERATIONS : TAB_LEN;

  logic signed [33:0] x, y, z;
  logic [4:0]         iter;
  logic               busy;
  logic               flip;
  cordic_mode_t       mode;
  logic               dir;
  logic signed [33:0] xs, ys;
  logic [31:0]        ang_adj;

  assign xs = x >>> iter;
  assign ys = y >>> iter;
  // Rotation: positive direction when z >= 0; vectoring when y < 0
  assign dir = (mode == CM_ROT) ? !z[33] : y[33];
  assign ang_adj = angle + 32'h8000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        iter <= '0;
        mode <= ctl.mode;
        if (ctl.mode == CM_ROT) begin
          x <= CORDIC_GAIN;
          y <= '0;
          flip <= ((angle + 32'h4000_0000) >> 31) != 32'd0;
          if (((angle + 32'h4000_0000) >> 31) != 32'd0)
            z <= {{2{ang_adj[31]}}, ang_adj};
          else
            z <= {{2{angle[31]}}, angle};
        end else begin
          flip <= 1'b0;
          z <= '0;
          if (vec_x[33]) begin
            x <= -vec_x;
            y <= -vec_y;
          end else begin
            x <= vec_x;
            y <= vec_y;
          end
        end
      end else if (busy) begin
        // Both modes step z against the direction of the micro-rotation
        if (dir) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_entry(iter);
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_entry(iter);
        end
        iter <= iter + 5'd1;
        if (iter == 5'(N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res_x = flip ? -x : x;
  assign res_y = flip ? -y : y;
  assign res_z = z[31:0];
endmodule
